### rtl/c2p_pkg.sv
// shared types, constants and arctangent table for the cartesian-to-polar core
`timescale 1ns / 1ps

package c2p_pkg;

    localparam int COORD_WIDTH         = 16;
    localparam int ROTATION_STAGES     = 16;
    localparam int ANGLE_FRACTION_BITS = 7;

    localparam int GUARD_BITS      = 8;
    localparam int TABLE_FRAC      = 24;
    localparam int GAIN_FRAC       = 22;
    localparam int GAIN_WIDTH      = 22;
    localparam int TABLE_IDX_WIDTH = 5;
    localparam int ANGLE_WIDTH     = 9 + ANGLE_FRACTION_BITS;
    localparam int XY_WIDTH        = COORD_WIDTH + GUARD_BITS + 3;
    localparam int Z_WIDTH         = 32;
    localparam int PROD_WIDTH      = XY_WIDTH + GAIN_WIDTH;
    localparam int STAGE_IDX_WIDTH = (ROTATION_STAGES > 1) ? $clog2(ROTATION_STAGES) : 1;

    localparam int RADIUS_SHIFT = GAIN_FRAC + GUARD_BITS;
    localparam int ANGLE_SHIFT  = TABLE_FRAC - ANGLE_FRACTION_BITS;

    localparam logic [GAIN_WIDTH-1:0] INV_GAIN = GAIN_WIDTH'(2547003);
    localparam logic [PROD_WIDTH-1:0] RADIUS_ROUND = PROD_WIDTH'(1) << (RADIUS_SHIFT - 1);
    localparam logic [Z_WIDTH:0]      ANGLE_ROUND  = (Z_WIDTH + 1)'(1) << (ANGLE_SHIFT - 1);
    localparam logic signed [Z_WIDTH-1:0] Z_RIGHT  = Z_WIDTH'(90) << TABLE_FRAC;

    localparam logic [ANGLE_WIDTH:0] ANG_90  = (ANGLE_WIDTH + 1)'(90)  << ANGLE_FRACTION_BITS;
    localparam logic [ANGLE_WIDTH:0] ANG_180 = (ANGLE_WIDTH + 1)'(180) << ANGLE_FRACTION_BITS;
    localparam logic [ANGLE_WIDTH:0] ANG_270 = (ANGLE_WIDTH + 1)'(270) << ANGLE_FRACTION_BITS;
    localparam logic [ANGLE_WIDTH:0] ANG_360 = (ANGLE_WIDTH + 1)'(360) << ANGLE_FRACTION_BITS;

    localparam logic [2:0] QUAD_AXIS = 3'd0;
    localparam logic [2:0] QUAD_1    = 3'd1;
    localparam logic [2:0] QUAD_2    = 3'd2;
    localparam logic [2:0] QUAD_3    = 3'd3;
    localparam logic [2:0] QUAD_4    = 3'd4;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
    } point_t;

    typedef struct packed {
        logic [2:0]             quadrant;
        logic [COORD_WIDTH-1:0] radius;
        logic [ANGLE_WIDTH-1:0] angle;
    } polar_t;

    // values that ride alongside the rotation untouched
    typedef struct packed {
        logic [2:0]             quad;
        logic                   on_axis;
        logic [COORD_WIDTH-1:0] axis_radius;
        logic [ANGLE_WIDTH-1:0] axis_angle;
    } side_t;

    typedef struct packed {
        logic signed [XY_WIDTH-1:0] vx;
        logic signed [XY_WIDTH-1:0] vy;
        logic signed [Z_WIDTH-1:0]  z;
        side_t                      side;
    } vec_t;

    // round(atan(2^-i) degrees * 2^24)
    function automatic logic [Z_WIDTH-1:0] atan_q24(input logic [TABLE_IDX_WIDTH-1:0] idx);
        logic [Z_WIDTH-1:0] v;
        case (idx)
            5'd0:    v = 32'd754974720;
            5'd1:    v = 32'd445687602;
            5'd2:    v = 32'd235489088;
            5'd3:    v = 32'd119537938;
            5'd4:    v = 32'd60000934;
            5'd5:    v = 32'd30029717;
            5'd6:    v = 32'd15018523;
            5'd7:    v = 32'd7509720;
            5'd8:    v = 32'd3754917;
            5'd9:    v = 32'd1877466;
            5'd10:   v = 32'd938734;
            5'd11:   v = 32'd469367;
            5'd12:   v = 32'd234684;
            5'd13:   v = 32'd117342;
            5'd14:   v = 32'd58671;
            5'd15:   v = 32'd29335;
            5'd16:   v = 32'd14668;
            5'd17:   v = 32'd7334;
            5'd18:   v = 32'd3667;
            5'd19:   v = 32'd1833;
            5'd20:   v = 32'd917;
            5'd21:   v = 32'd458;
            5'd22:   v = 32'd229;
            5'd23:   v = 32'd115;
            5'd24:   v = 32'd57;
            5'd25:   v = 32'd29;
            5'd26:   v = 32'd14;
            5'd27:   v = 32'd7;
            5'd28:   v = 32'd4;
            5'd29:   v = 32'd2;
            5'd30:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/cartesian_to_polar_core.sv
// top level of the pipelined cartesian-to-polar converter
//
// usage: a point (x_coord, y_coord) is offered on point with point_valid and is
// taken in a transfer at a rising edge where point_valid is high and point_stall
// is low. each point yields exactly one result on polar (quadrant, radius, angle
// in 1/128 degree), presented with polar_valid and taken when polar_stall is low.
// the pipeline holds one fold stage, one cell per rotation, a multiply register
// and the output register. throughput is one point per cycle while the receiver
// does not stall; every cell of the chain moves its data to its neighbor each
// cycle unless it is held. when the receiver stalls, results stay held and the
// chain keeps closing up bubbles; point_stall rises only once every stage holds
// a point. rst_n clears all valid flags asynchronously; the data registers are
// not reset, and the block needs no initialization pass after reset.
`timescale 1ns / 1ps

module cartesian_to_polar_core
    import c2p_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   point_valid,
    output logic   point_stall,
    input  point_t point,
    output logic   polar_valid,
    input  logic   polar_stall,
    output polar_t polar
);

    // chain links: index 0 is the fold stage output, index k+1 is cell k output
    logic                       link_valid [ROTATION_STAGES+1];
    vec_t                       link_data  [ROTATION_STAGES+1];
    logic                       link_hold  [ROTATION_STAGES+1];

    // fold the point into the first quadrant and settle on-axis cases
    c2p_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point_valid),
        .in_data   (point),
        .hold      (point_stall),
        .out_valid (link_valid[0]),
        .out_data  (link_data[0]),
        .out_hold  (link_hold[0])
    );

    // rotation chain, one shift-and-add cell per stage
    for (genvar i = 0; i < ROTATION_STAGES; i++)
    begin : g_cell
        c2p_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .stage_index (STAGE_IDX_WIDTH'(i)),
            .in_valid    (link_valid[i]),
            .in_data     (link_data[i]),
            .hold        (link_hold[i]),
            .out_valid   (link_valid[i+1]),
            .out_data    (link_data[i+1]),
            .out_hold    (link_hold[i+1])
        );
    end

    // gain correction and angle unfolding, then the output register
    c2p_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[ROTATION_STAGES]),
        .in_data   (link_data[ROTATION_STAGES]),
        .hold      (link_hold[ROTATION_STAGES]),
        .out_valid (polar_valid),
        .out_data  (polar),
        .out_hold  (polar_stall)
    );

    // the input only backs up when the output is holding a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> (polar_valid && polar_stall))
        else $error("input stalled while output is free");

    // results on an axis carry one of the four exact axis angles
    assert property (@(posedge clk) disable iff (!rst_n)
        (polar_valid && polar.quadrant == QUAD_AXIS) |->
        (polar.angle == '0 || polar.angle == ANG_90[ANGLE_WIDTH-1:0] ||
         polar.angle == ANG_180[ANGLE_WIDTH-1:0] ||
         polar.angle == ANG_270[ANGLE_WIDTH-1:0]))
        else $error("axis result with a non-axis angle");

    // first-quadrant angles stay within 0..90 degrees
    assert property (@(posedge clk) disable iff (!rst_n)
        (polar_valid && polar.quadrant == QUAD_1) |->
        ({1'b0, polar.angle} <= ANG_90))
        else $error("first quadrant angle out of range");

    // second-quadrant angles stay within 90..180 degrees
    assert property (@(posedge clk) disable iff (!rst_n)
        (polar_valid && polar.quadrant == QUAD_2) |->
        ({1'b0, polar.angle} >= ANG_90 && {1'b0, polar.angle} <= ANG_180))
        else $error("second quadrant angle out of range");

    // a result that waits on a stall keeps its quadrant
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(polar_valid && polar_stall) |-> (polar_valid &&
        $stable(polar.quadrant)))
        else $error("held result changed under stall");

endmodule

### rtl/c2p_fold.sv
// input stage: magnitudes, quadrant and on-axis results
`timescale 1ns / 1ps

module c2p_fold
    import c2p_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  point_t in_data,
    output logic   hold,
    output logic   out_valid,
    output vec_t   out_data,
    input  logic   out_hold
);

    logic                   valid_reg;
    logic                   valid_next;
    vec_t                   data_reg;
    vec_t                   data_next;
    logic                   xneg;
    logic                   yneg;
    logic [COORD_WIDTH-1:0] ax;
    logic [COORD_WIDTH-1:0] ay;
    logic [ANGLE_WIDTH:0]   axis_ang;

    assign hold = valid_reg && out_hold;

    always_comb
    begin
        xneg = in_data.x_coord[COORD_WIDTH-1];
        yneg = in_data.y_coord[COORD_WIDTH-1];
        ax = xneg ? (~in_data.x_coord + 1'b1) : in_data.x_coord;
        ay = yneg ? (~in_data.y_coord + 1'b1) : in_data.y_coord;

        if (ay == '0)
        begin
            axis_ang = (ax != '0 && xneg) ? ANG_180 : '0;
        end
        else
        begin
            axis_ang = yneg ? ANG_270 : ANG_90;
        end

        data_next.vx = {3'b000, ax, {GUARD_BITS{1'b0}}};
        data_next.vy = {3'b000, ay, {GUARD_BITS{1'b0}}};
        data_next.z  = '0;
        data_next.side.on_axis     = (ax == '0) || (ay == '0);
        data_next.side.axis_radius = ax | ay;
        data_next.side.axis_angle  = axis_ang[ANGLE_WIDTH-1:0];
        if (data_next.side.on_axis)
            data_next.side.quad = QUAD_AXIS;
        else if (!xneg)
            data_next.side.quad = yneg ? QUAD_4 : QUAD_1;
        else
            data_next.side.quad = yneg ? QUAD_3 : QUAD_2;

        valid_next = hold ? valid_reg : in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (!hold && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/c2p_cell.sv
// one vectoring rotation cell of the chain
`timescale 1ns / 1ps

module c2p_cell
    import c2p_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [STAGE_IDX_WIDTH-1:0] stage_index,
    input  logic                       in_valid,
    input  vec_t                       in_data,
    output logic                       hold,
    output logic                       out_valid,
    output vec_t                       out_data,
    input  logic                       out_hold
);

    logic                       valid_reg;
    logic                       valid_next;
    vec_t                       data_reg;
    vec_t                       data_next;
    logic signed [XY_WIDTH-1:0] dx;
    logic signed [XY_WIDTH-1:0] dy;
    logic signed [Z_WIDTH-1:0]  step_angle;

    assign hold = valid_reg && out_hold;

    always_comb
    begin
        dx = in_data.vy >>> stage_index;
        dy = in_data.vx >>> stage_index;
        step_angle = atan_q24(TABLE_IDX_WIDTH'(stage_index));
        data_next = in_data;
        // y non-negative: rotate clockwise
        if (!in_data.vy[XY_WIDTH-1])
        begin
            data_next.vx = in_data.vx + dx;
            data_next.vy = in_data.vy - dy;
            data_next.z  = in_data.z + step_angle;
        end
        else
        begin
            data_next.vx = in_data.vx - dx;
            data_next.vy = in_data.vy + dy;
            data_next.z  = in_data.z - step_angle;
        end
        valid_next = hold ? valid_reg : in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (!hold && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/c2p_post.sv
// gain correction, angle unfolding and output register
`timescale 1ns / 1ps

module c2p_post
    import c2p_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  vec_t   in_data,
    output logic   hold,
    output logic   out_valid,
    output polar_t out_data,
    input  logic   out_hold
);

    logic                    mul_valid_reg;
    logic                    mul_valid_next;
    logic [PROD_WIDTH-1:0]   prod_reg;
    logic [PROD_WIDTH-1:0]   prod_next;
    logic [ANGLE_WIDTH-1:0]  ang_reg;
    logic [ANGLE_WIDTH-1:0]  ang_next;
    side_t                   side_reg;
    logic                    mul_hold;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    polar_t                  out_reg;
    polar_t                  out_next;

    logic [Z_WIDTH-1:0]      z_clamped;
    logic [Z_WIDTH:0]        z_rounded;
    logic [ANGLE_WIDTH:0]    a_first;
    logic [ANGLE_WIDTH:0]    a_turn;
    logic [PROD_WIDTH-1:0]   prod_rounded;

    assign mul_hold = out_valid_reg && out_hold;
    assign hold     = mul_valid_reg && mul_hold;

    always_comb
    begin
        prod_next = PROD_WIDTH'(in_data.vx) * PROD_WIDTH'(INV_GAIN);

        if (in_data.z[Z_WIDTH-1])
            z_clamped = '0;
        else if (in_data.z > Z_RIGHT)
            z_clamped = Z_RIGHT;
        else
            z_clamped = in_data.z;
        z_rounded = {1'b0, z_clamped} + ANGLE_ROUND;
        a_first   = {1'b0, z_rounded[ANGLE_SHIFT +: ANGLE_WIDTH]};

        case (in_data.side.quad)
            QUAD_2:  a_turn = ANG_180 - a_first;
            QUAD_3:  a_turn = ANG_180 + a_first;
            QUAD_4:  a_turn = (a_first == '0) ? '0 : (ANG_360 - a_first);
            default: a_turn = a_first;
        endcase
        ang_next = a_turn[ANGLE_WIDTH-1:0];

        mul_valid_next = hold ? mul_valid_reg : in_valid;
    end

    always_comb
    begin
        prod_rounded = prod_reg + RADIUS_ROUND;
        out_next.quadrant = side_reg.quad;
        if (side_reg.on_axis)
        begin
            out_next.radius = side_reg.axis_radius;
            out_next.angle  = side_reg.axis_angle;
        end
        else
        begin
            out_next.radius = prod_rounded[RADIUS_SHIFT +: COORD_WIDTH];
            out_next.angle  = ang_reg;
        end
        out_valid_next = mul_hold ? out_valid_reg : mul_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold && in_valid)
        begin
            prod_reg <= prod_next;
            ang_reg  <= ang_next;
            side_reg <= in_data.side;
        end
        if (!mul_hold && mul_valid_reg)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### tb/testbench.sv
// self-checking testbench for the pipelined cartesian-to-polar converter
`timescale 1ns / 1ps

module testbench
    import c2p_pkg::*;
;

    // ------------------------------------------------------------------
    // expected-result tracking: converts every accepted point on its own
    // and compares the results in order, field by field
    // ------------------------------------------------------------------
    class polar_scoreboard;
        polar_t pending_polar [$];
        longint arctan_q24 [32];    // atan(2^-i) in degrees, 24 fraction bits
        int     checked_count;
        int     axis_count;
        int     error_count;

        function new();
            arctan_q24 = '{
                754974720, 445687602, 235489088, 119537938,
                60000934,  30029717,  15018523,  7509720,
                3754917,   1877466,   938734,    469367,
                234684,    117342,    58671,     29335,
                14668,     7334,      3667,      1833,
                917,       458,       229,       115,
                57,        29,        14,        7,
                4,         2,         1,         0
            };
        endfunction

        function polar_t convert(point_t p);
            polar_t r;
            longint xs, ys, ax, ay, vx, vy, dx, dy, z, a, rad, ang;
            bit     xneg, yneg;
            xs = $signed(p.x_coord);
            ys = $signed(p.y_coord);
            xneg = xs < 0;
            yneg = ys < 0;
            ax = xneg ? -xs : xs;
            ay = yneg ? -ys : ys;
            if (ax == 0 || ay == 0)
            begin
                // on an axis or the origin: exact angle, radius is the one magnitude
                r.quadrant = QUAD_AXIS;
                rad = ax | ay;
                if (ay == 0)
                    ang = (ax != 0 && xneg) ? (longint'(180) << ANGLE_FRACTION_BITS) : 0;
                else
                    ang = yneg ? (longint'(270) << ANGLE_FRACTION_BITS)
                               : (longint'(90) << ANGLE_FRACTION_BITS);
            end
            else
            begin
                if (!xneg)
                    r.quadrant = yneg ? QUAD_4 : QUAD_1;
                else
                    r.quadrant = yneg ? QUAD_3 : QUAD_2;
                // vectoring on the folded point, y driven toward zero
                vx = ax << GUARD_BITS;
                vy = ay << GUARD_BITS;
                z  = 0;
                for (int i = 0; i < ROTATION_STAGES && i < 32; i++)
                begin
                    dx = vy >>> i;
                    dy = vx >>> i;
                    if (vy >= 0)
                    begin
                        vx = vx + dx;
                        vy = vy - dy;
                        z  = z + arctan_q24[i];
                    end
                    else
                    begin
                        vx = vx - dx;
                        vy = vy + dy;
                        z  = z - arctan_q24[i];
                    end
                end
                rad = (vx * longint'(INV_GAIN)
                       + (longint'(1) << (GAIN_FRAC + GUARD_BITS - 1)))
                      >>> (GAIN_FRAC + GUARD_BITS);
                if (z < 0)
                    z = 0;
                if (z > (longint'(90) << TABLE_FRAC))
                    z = longint'(90) << TABLE_FRAC;
                a = (z + (longint'(1) << (TABLE_FRAC - 1 - ANGLE_FRACTION_BITS)))
                    >>> (TABLE_FRAC - ANGLE_FRACTION_BITS);
                case (r.quadrant)
                    QUAD_1:  ang = a;
                    QUAD_2:  ang = (longint'(180) << ANGLE_FRACTION_BITS) - a;
                    QUAD_3:  ang = (longint'(180) << ANGLE_FRACTION_BITS) + a;
                    default:
                    begin
                        ang = (longint'(360) << ANGLE_FRACTION_BITS) - a;
                        if (ang == (longint'(360) << ANGLE_FRACTION_BITS))
                            ang = 0;
                    end
                endcase
            end
            r.radius = COORD_WIDTH'(rad);
            r.angle  = ANGLE_WIDTH'(ang);
            return r;
        endfunction

        function void note_point(point_t p);
            polar_t want;
            want = convert(p);
            if (want.quadrant == QUAD_AXIS)
                axis_count++;
            pending_polar.push_back(want);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                error_count++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_polar(polar_t got);
            polar_t want;
            if (pending_polar.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                         $time, got.quadrant, got.radius, got.angle);
                return;
            end
            want = pending_polar.pop_front();
            checked_count++;
            compare_field("quadrant", want.quadrant, got.quadrant);
            compare_field("radius", want.radius, got.radius);
            compare_field("angle", want.angle, got.angle);
        endfunction

        function int outstanding();
            return pending_polar.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block interface
    // ------------------------------------------------------------------
    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   point_valid = 1'b0;
    logic   point_stall;
    point_t point       = '0;
    logic   polar_valid;
    logic   polar_stall = 1'b0;
    polar_t polar;

    polar_scoreboard sb = new();

    // idle rates in percent, changed per phase by the stimulus process
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    always #5 clk = ~clk;

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    cartesian_to_polar_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .polar_valid (polar_valid),
        .polar_stall (polar_stall),
        .polar       (polar)
    );

    // ------------------------------------------------------------------
    // result side: check each transfer, then pick the next stall value
    // values read right after the edge are the ones the edge sampled
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (polar_valid && !polar_stall)
                sb.check_polar(polar);
            polar_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // point side
    // ------------------------------------------------------------------

    // one point transfer; valid drops only for an idle gap, so a back-to-back
    // point never sees valid lowered and raised within one step
    task automatic send_point(input point_t p);
        if ($urandom_range(99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        point_valid <= 1'b1;
        point       <= p;
        do @(posedge clk); while (point_stall);
        sb.note_point(p);
    endtask

    function automatic point_t make_point(int x, int y);
        point_t p;
        p.x_coord = COORD_WIDTH'(x);
        p.y_coord = COORD_WIDTH'(y);
        return p;
    endfunction

    // coordinate values at the edges of the signed range
    function automatic int extreme_coord();
        case ($urandom_range(5))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            default: return 32767;
        endcase
    endfunction

    // weighted mix: full-range points plus axes, corners, near-axis,
    // tiny, diagonal and near-full-turn points
    function automatic point_t random_point();
        point_t p;
        int     m;
        p.x_coord = COORD_WIDTH'($urandom);
        p.y_coord = COORD_WIDTH'($urandom);
        case ($urandom_range(11))
            0:
            begin
                if ($urandom_range(1))
                    p.x_coord = '0;
                else
                    p.y_coord = '0;
            end
            1:       p = make_point(extreme_coord(), extreme_coord());
            2:
            begin
                if ($urandom_range(1))
                    p.x_coord = COORD_WIDTH'(int'($urandom_range(6)) - 3);
                else
                    p.y_coord = COORD_WIDTH'(int'($urandom_range(6)) - 3);
            end
            3:       p = make_point(int'($urandom_range(16)) - 8,
                                    int'($urandom_range(16)) - 8);
            4:
            begin
                m = $urandom_range(32767);
                p = make_point($urandom_range(1) ? m : -m, $urandom_range(1) ? m : -m);
            end
            5:       p = make_point($urandom_range(32767, 16384),
                                    -int'($urandom_range(3, 1)));
            default: ;
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------
    // stimulus: directed points, a full drain, then three throttling phases
    // ------------------------------------------------------------------
    initial
    begin
        point_t directed [$];

        directed = '{
            make_point(0, 0),                   // origin
            make_point(1, 0),      make_point(32767, 0),
            make_point(0, 1),      make_point(0, 32767),
            make_point(-1, 0),     make_point(-32768, 0),
            make_point(0, -1),     make_point(0, -32768),
            make_point(1, 1),      make_point(-1, 1),
            make_point(-1, -1),    make_point(1, -1),
            make_point(32767, 32767),
            make_point(-32768, -32768),         // largest radius
            make_point(-32768, 32767),
            make_point(32767, -32768),
            make_point(-32768, 1), make_point(1, -32768),
            make_point(32767, -1),              // rounds to a full turn
            make_point(30000, -2),
            make_point(3, 4),      make_point(-3, -4),
            make_point(-12345, 23456)
        };

        do @(posedge clk); while (!rst_n);

        send_idle_pct  = 26;
        recv_stall_pct = 68;
        foreach (directed[i])
            send_point(directed[i]);

        // hold off until the pipeline has emptied completely
        point_valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 26;
                    recv_stall_pct = 68;
                end
                1:
                begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 26;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int k = 0; k < 200; k++)
                send_point(random_point());
        end

        point_valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
        // watch for stray results a little past the pipeline depth
        repeat (ROTATION_STAGES + 10) @(posedge clk);

        $display("converted %0d points (%0d on an axis or the origin) through directed,",
                 sb.checked_count, sb.axis_count);
        $display("drain and three sender/receiver throttling phases");
        if (sb.error_count == 0 && sb.outstanding() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // hard limit, far above the slowest legal run
    initial
    begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

### filelist.f
rtl/c2p_pkg.sv
rtl/c2p_fold.sv
rtl/c2p_cell.sv
rtl/c2p_post.sv
rtl/cartesian_to_polar_core.sv
tb/testbench.sv
